FILE: rtl/core/hdlf_pkg.sv
// hdlf_pkg: constants, control word layout and microcode table of the hex dump formatter
// no dependencies; used by the interfaces, the sequencer and the top level

package hdlf_pkg;

    localparam int LINE_BYTES  = 16;
    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int IDX_W       = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W      = 64;
    localparam int ADDR_DIGITS = ADDR_W / 4;
    localparam int DIG_W       = $clog2(ADDR_DIGITS);
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CH_NL    = 7'h0a;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

    // microcode step addresses
    typedef logic [3:0] t_step;
    localparam t_step S_IDLE  = 4'd0;
    localparam t_step S_ADDR  = 4'd1;
    localparam t_step S_COLON = 4'd2;
    localparam t_step S_SPC   = 4'd3;
    localparam t_step S_HI    = 4'd4;
    localparam t_step S_LO    = 4'd5;
    localparam t_step S_PCHK  = 4'd6;
    localparam t_step S_PADA  = 4'd7;
    localparam t_step S_PADB  = 4'd8;
    localparam t_step S_PADC  = 4'd9;
    localparam t_step S_SEP   = 4'd10;
    localparam t_step S_TXT   = 4'd11;
    localparam t_step S_NL    = 4'd12;

    typedef enum logic [2:0] {
        SRC_ADDR,
        SRC_COLON,
        SRC_SPACE,
        SRC_HI,
        SRC_LO,
        SRC_TEXT,
        SRC_NL
    } t_src;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_ALWAYS,
        EM_POS_EVEN,
        EM_IDX_EVEN
    } t_emit;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_FILL_NZ,
        JC_DIG_MORE,
        JC_LINE_OPEN,
        JC_PAD_DONE,
        JC_TXT_MORE
    } t_jc;

    typedef struct packed {
        t_src  src;
        t_emit emit;
        t_jc   jc;
        t_step target;
        logic  wait_in;
        logic  last_open;
        logic  last_always;
        logic  dig_step;
        logic  off_inc;
        logic  fill_upd;
        logic  set_pad;
        logic  idx_inc;
        logic  idx_clr;
        logic  line_end;
    } t_ctl;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic pos_even;
        logic idx_even;
        logic fill_nz;
        logic dig_more;
        logic line_open;
        logic pad_done;
        logic txt_more;
    } t_flags;

    localparam t_ctl CTL_NOP = '{
        src: SRC_SPACE, emit: EM_NONE, jc: JC_NEXT, target: S_IDLE,
        wait_in: 1'b0, last_open: 1'b0, last_always: 1'b0, dig_step: 1'b0,
        off_inc: 1'b0, fill_upd: 1'b0, set_pad: 1'b0, idx_inc: 1'b0,
        idx_clr: 1'b0, line_end: 1'b0
    };

    function automatic t_ctl ctl_rom(t_step s);
        t_ctl c;
        c = CTL_NOP;
        unique case (s)
            S_IDLE: begin
                c.wait_in = 1'b1;
                c.jc      = JC_FILL_NZ;
                c.target  = S_SPC;
            end
            S_ADDR: begin
                c.src      = SRC_ADDR;
                c.emit     = EM_ALWAYS;
                c.dig_step = 1'b1;
                c.jc       = JC_DIG_MORE;
                c.target   = S_ADDR;
            end
            S_COLON: begin
                c.src  = SRC_COLON;
                c.emit = EM_ALWAYS;
            end
            S_SPC: begin
                c.src  = SRC_SPACE;
                c.emit = EM_POS_EVEN;
            end
            S_HI: begin
                c.src     = SRC_HI;
                c.emit    = EM_ALWAYS;
                c.off_inc = 1'b1;
            end
            S_LO: begin
                c.src       = SRC_LO;
                c.emit      = EM_ALWAYS;
                c.last_open = 1'b1;
                c.fill_upd  = 1'b1;
                c.set_pad   = 1'b1;
                c.jc        = JC_LINE_OPEN;
                c.target    = S_IDLE;
            end
            S_PCHK: begin
                c.jc     = JC_PAD_DONE;
                c.target = S_SEP;
            end
            S_PADA: begin
                c.src  = SRC_SPACE;
                c.emit = EM_IDX_EVEN;
            end
            S_PADB: begin
                c.src  = SRC_SPACE;
                c.emit = EM_ALWAYS;
            end
            S_PADC: begin
                c.src     = SRC_SPACE;
                c.emit    = EM_ALWAYS;
                c.idx_inc = 1'b1;
                c.jc      = JC_ALWAYS;
                c.target  = S_PCHK;
            end
            S_SEP: begin
                c.src     = SRC_SPACE;
                c.emit    = EM_ALWAYS;
                c.idx_clr = 1'b1;
            end
            S_TXT: begin
                c.src     = SRC_TEXT;
                c.emit    = EM_ALWAYS;
                c.idx_inc = 1'b1;
                c.jc      = JC_TXT_MORE;
                c.target  = S_TXT;
            end
            S_NL: begin
                c.src         = SRC_NL;
                c.emit        = EM_ALWAYS;
                c.last_always = 1'b1;
                c.line_end    = 1'b1;
                c.jc          = JC_ALWAYS;
                c.target      = S_IDLE;
            end
            default: begin
                c.jc     = JC_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
        if (n < 4'd10) begin
            return CH_ZERO + CHAR_W'(n);
        end else begin
            return CH_LOW_A + CHAR_W'(n - 4'd10);
        end
    endfunction

endpackage

FILE: rtl/core/hdlf_if.sv
// hdlf_in_if and hdlf_out_if: valid/ready channels of the hex dump formatter
// depends on hdlf_pkg for the field widths

interface hdlf_in_if
    import hdlf_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdlf_out_if
    import hdlf_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: rtl/core/hdlf_ram.sv
// hdlf_ram: generic single write port, single read port RAM with registered read
// no dependencies

module hdlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/hdlf_seq.sv
// hdlf_seq: microcode step counter, control table lookup and jump logic
// depends on hdlf_pkg for the control word, flags and the table

module hdlf_seq
    import hdlf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl,
    output logic   o_adv,
    output logic   o_emit
);

    t_step r_step;
    t_step n_step;
    t_ctl  ctl;
    logic  want_emit;
    logic  take;

    assign ctl = ctl_rom(r_step);

    always_comb begin
        case (ctl.emit)
            EM_ALWAYS:   want_emit = 1'b1;
            EM_POS_EVEN: want_emit = i_flags.pos_even;
            EM_IDX_EVEN: want_emit = i_flags.idx_even;
            default:     want_emit = 1'b0;
        endcase
    end

    // a step that emits completes only when the output register can load
    assign o_adv  = ctl.wait_in ? i_flags.in_valid : (!want_emit || i_flags.out_free);
    assign o_emit = want_emit && i_flags.out_free;

    always_comb begin
        unique case (ctl.jc)
            JC_NEXT:      take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_FILL_NZ:   take = i_flags.fill_nz;
            JC_DIG_MORE:  take = i_flags.dig_more;
            JC_LINE_OPEN: take = i_flags.line_open;
            JC_PAD_DONE:  take = i_flags.pad_done;
            JC_TXT_MORE:  take = i_flags.txt_more;
            default:      take = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (o_adv) begin
            n_step = take ? ctl.target : r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = ctl;

endmodule

FILE: rtl/core/hex_dump_line_formatter.sv
// hex_dump_line_formatter: top level, datapath around the microcode sequencer
// depends on hdlf_pkg, hdlf_if, hdlf_ram and hdlf_seq

// Turns a byte stream into hex dump text, one 7-bit ASCII character per output item,
// 16 bytes to a line: "<16 hex digit address>:", the hex pairs with a space before
// each even position, blank padding on a short line, a space, the printable bytes
// (others shown as '.') and a newline. last_char marks the final character caused by
// each input byte. Bytes are taken one at a time; each is handled by a microcode
// program that emits at most one character per cycle into the output register, while
// the output is not held off by ready. The base address is loaded from i_cfg_data
// when i_cfg_we is high and applies from the next line opened.

module hex_dump_line_formatter
    import hdlf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    hdlf_in_if.sink           i_in,
    hdlf_out_if.source        o_out
);

    t_ctl   ctl;
    t_flags flags;
    logic   adv;
    logic   emit;
    logic   accept;

    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_off;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_fill;
    logic [DIG_W-1:0]  r_dig;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_ov;
    logic [CHAR_W-1:0] r_och;
    logic              r_olast;

    logic [BYTE_W-1:0] rd_byte;
    logic [CHAR_W-1:0] ch;
    logic              line_open;
    logic              out_free;

    hdlf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_adv   (adv),
        .o_emit  (emit)
    );

    // read address follows the next text index so the data is ready in the next cycle
    hdlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_fill),
        .i_wdata (i_in.data_byte),
        .i_raddr (n_idx[POS_W-1:0]),
        .o_rdata (rd_byte)
    );

    assign i_in.ready = ctl.wait_in;
    assign accept     = i_in.valid && ctl.wait_in;
    assign out_free   = !r_ov || o_out.ready;
    assign line_open  = (r_pos != POS_W'(LINE_BYTES - 1)) && !r_last;

    always_comb begin
        flags.in_valid  = i_in.valid;
        flags.out_free  = out_free;
        flags.pos_even  = !r_pos[0];
        flags.idx_even  = !r_idx[0];
        flags.fill_nz   = (r_fill != '0);
        flags.dig_more  = (r_dig != DIG_W'(ADDR_DIGITS - 1));
        flags.line_open = line_open;
        flags.pad_done  = (r_idx == IDX_W'(LINE_BYTES));
        flags.txt_more  = (r_idx != IDX_W'(r_pos));
    end

    always_comb begin
        case (ctl.src)
            SRC_ADDR:  ch = hex_char(r_addr[ADDR_W-1 -: 4]);
            SRC_COLON: ch = CH_COLON;
            SRC_HI:    ch = hex_char(r_byte[7:4]);
            SRC_LO:    ch = hex_char(r_byte[3:0]);
            SRC_TEXT:  ch = (rd_byte >= PRINT_LO && rd_byte <= PRINT_HI) ?
                            rd_byte[CHAR_W-1:0] : CH_DOT;
            SRC_NL:    ch = CH_NL;
            default:   ch = CH_SPACE;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (adv) begin
            if (ctl.set_pad) begin
                n_idx = IDX_W'(r_pos) + IDX_W'(1);
            end else if (ctl.idx_clr) begin
                n_idx = '0;
            end else if (ctl.idx_inc) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_off  <= '0;
            r_fill <= '0;
            r_dig  <= '0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            r_idx <= n_idx;
            if (accept) begin
                r_dig <= '0;
            end else if (adv && ctl.dig_step) begin
                r_dig <= r_dig + DIG_W'(1);
            end
            if (adv && ctl.off_inc) begin
                r_off <= r_off + ADDR_W'(1);
            end else if (adv && ctl.line_end && r_last) begin
                r_off <= '0;
            end
            if (adv && ctl.line_end) begin
                r_fill <= '0;
            end else if (adv && ctl.fill_upd) begin
                r_fill <= r_pos + POS_W'(1);
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
            r_pos  <= r_fill;
            r_addr <= r_base + r_off;
        end else if (adv && ctl.dig_step) begin
            r_addr <= {r_addr[ADDR_W-5:0], 4'h0};
        end
        if (emit) begin
            r_och   <= ch;
            r_olast <= ctl.last_always || (ctl.last_open && line_open);
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_char  = r_och;
    assign o_out.last_char = r_olast;

endmodule
